### rtl/tplo_pkg.sv
package tplo_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MULQ,
    S_PREP,
    S_VEC,
    S_ROUND,
    S_RINIT,
    S_ROT,
    S_LEVER,
    S_POS,
    S_RMUL,
    S_RCHK,
    S_RDIV,
    S_REND,
    S_FIN
  } state_e;

  // CORDIC datapath widths
  localparam int CW = 37;
  localparam int ZW = 20;
  localparam int CORDIC_STEPS = 16;
  localparam int DIV_STEPS = 32;
  localparam int QUAT_PRODS = 6;

  localparam logic signed [15:0]    PI_Q13      = 16'sd25736;
  localparam logic signed [ZW-1:0]  PI_Q16      = 20'sd205887;
  localparam logic signed [ZW-1:0]  HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [CW-1:0]  CORDIC_K    = 37'sd652032874;
  localparam logic signed [32:0]    NS_PER_S    = 33'sd1000000000;
  localparam logic signed [20:0]    LEVER_RST   = 21'sd17039;

  // Arctangent of 2^-i in Q.16 radians
  function automatic logic signed [ZW-1:0] atan_lut(input logic [3:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      4'd0:  r = 20'sd51472;
      4'd1:  r = 20'sd30386;
      4'd2:  r = 20'sd16055;
      4'd3:  r = 20'sd8150;
      4'd4:  r = 20'sd4091;
      4'd5:  r = 20'sd2047;
      4'd6:  r = 20'sd1024;
      4'd7:  r = 20'sd512;
      4'd8:  r = 20'sd256;
      4'd9:  r = 20'sd128;
      4'd10: r = 20'sd64;
      4'd11: r = 20'sd32;
      4'd12: r = 20'sd16;
      4'd13: r = 20'sd8;
      4'd14: r = 20'sd4;
      4'd15: r = 20'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/tplo_cfg_if.sv
interface tplo_cfg_if;
  logic               valid;
  logic               ready;
  logic signed [20:0] lever_arm;

  modport source (output valid, output lever_arm, input ready);
  modport sink (input valid, input lever_arm, output ready);
endinterface

### rtl/tplo_pose_if.sv
interface tplo_pose_if;
  logic               valid;
  logic               ready;
  logic [47:0]        stamp_ns;
  logic signed [31:0] cam_x;
  logic signed [31:0] cam_y;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;

  modport source (output valid, output stamp_ns, output cam_x, output cam_y,
                  output quat_x, output quat_y, output quat_z, output quat_w,
                  input ready);
  modport sink (input valid, input stamp_ns, input cam_x, input cam_y,
                input quat_x, input quat_y, input quat_z, input quat_w,
                output ready);
endinterface

### rtl/tplo_odom_if.sv
interface tplo_odom_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] robot_x;
  logic signed [31:0] robot_y;
  logic signed [15:0] heading;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] yaw_rate;
  logic               zero_interval;

  modport source (output valid, output robot_x, output robot_y, output heading,
                  output vel_x, output vel_y, output yaw_rate, output zero_interval,
                  input ready);
  modport sink (input valid, input robot_x, input robot_y, input heading,
                input vel_x, input vel_y, input yaw_rate, input zero_interval,
                output ready);
endinterface

### rtl/tracking_pose_lever_arm_odometry.sv
// Steps for a nonzero interval: 6 quaternion products, 16 vectoring and 16 rotation CORDIC
// steps, 2 lever products, then three rate divisions; a zero interval skips the divisions.
// Gimbal lock or a zero y term skips vectoring; a saturated rate skips its division steps.
// A new pose is accepted only in idle, once the previous result has entered the output
// register; a stalled result holds the sequencer until the output is free.
// Reset (async, active low): lever arm 0.26 m, previous time/position/heading zero.
module tracking_pose_lever_arm_odometry (
  input  logic        clk_i,
  input  logic        rst_ni,
  tplo_cfg_if.sink    cfg_i,
  tplo_pose_if.sink   pose_i,
  tplo_odom_if.source odom_o
);

  localparam int CW = tplo_pkg::CW;
  localparam int ZW = tplo_pkg::ZW;

  tplo_pkg::state_e state_q, state_d;
  logic [4:0] cnt_q;
  logic [1:0] ch_q;

  logic signed [20:0] lever_q;

  // latched input
  logic [47:0]        stamp_q;
  logic signed [31:0] camx_q, camy_q;
  logic signed [15:0] qx_q, qy_q, qz_q, qw_q;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_q;
  logic signed [31:0] prod_q [tplo_pkg::QUAT_PRODS];

  // shared CORDIC registers
  logic signed [CW-1:0] cx_q, cy_q;
  logic signed [ZW-1:0] cz_q;
  logic                 neg_q;
  logic signed [15:0]   hd_q;

  logic signed [23:0] dc_q, ds_q;
  logic signed [31:0] rx_q, ry_q;
  logic               zero_q, dneg_q;
  logic [47:0]        ud_q;
  logic signed [32:0] dx_q, dy_q;
  logic signed [19:0] dh_q;

  // divider
  logic        rneg_q, big_q;
  logic [47:0] rem_q;
  logic [31:0] nq_q;
  logic signed [31:0] vx_q, vy_q, vt_q;

  // kept state
  logic [47:0]        last_stamp_q;
  logic signed [31:0] last_x_q, last_y_q;
  logic signed [15:0] last_hd_q;

  // output register
  logic               ov_q;
  logic signed [31:0] o_rx_q, o_ry_q, o_vx_q, o_vy_q, o_vt_q;
  logic signed [15:0] o_hd_q;
  logic               o_zero_q;

  logic pose_acc, out_free;
  assign pose_acc = pose_i.valid && pose_i.ready;
  assign out_free = !ov_q || odom_o.ready;

  // quaternion terms
  logic signed [32:0] g;
  logic signed [33:0] num, den;
  logic               gimbal;
  assign g = 33'(prod_q[0]) - 33'(prod_q[1]);
  assign num = (34'(prod_q[2]) + 34'(prod_q[3])) <<< 1;
  assign den = (34'sd1 <<< 30) - ((34'(prod_q[4]) + 34'(prod_q[5])) <<< 1);
  assign gimbal = (g >= (33'sd1 <<< 29)) || (g <= -(33'sd1 <<< 29));

  // CORDIC micro-rotation; sigma_pos means x -= y>>i, y += x>>i, z -= atan
  logic [3:0]           sh;
  logic signed [CW-1:0] xs, ys, xn, yn;
  logic signed [ZW-1:0] at, zn;
  logic                 sigma_pos, skip;
  assign sh = cnt_q[3:0];
  assign xs = cx_q >>> sh;
  assign ys = cy_q >>> sh;
  assign at = tplo_pkg::atan_lut(sh);
  assign sigma_pos = (state_q == tplo_pkg::S_VEC) ? (cy_q < 0) : (cz_q >= 0);
  assign skip = (state_q == tplo_pkg::S_VEC) && (cy_q == '0);
  assign xn = sigma_pos ? cx_q - ys : cx_q + ys;
  assign yn = sigma_pos ? cy_q + xs : cy_q - xs;
  assign zn = sigma_pos ? cz_q - at : cz_q + at;

  // heading rounding to Q3.13
  logic signed [ZW-1:0] zr;
  logic signed [15:0]   hd_rnd;
  assign zr = (cz_q + ZW'(4)) >>> 3;
  always_comb begin
    if (zr > ZW'(tplo_pkg::PI_Q13)) hd_rnd = tplo_pkg::PI_Q13;
    else if (zr < -ZW'(tplo_pkg::PI_Q13)) hd_rnd = -tplo_pkg::PI_Q13;
    else hd_rnd = zr[15:0];
  end

  // rotation angle reduction
  logic signed [ZW-1:0] z8;
  assign z8 = ZW'(hd_q) <<< 3;

  // lever products rounding
  logic signed [65:0] mul_rnd;
  logic signed [32:0] cos_v, sin_v;
  assign mul_rnd = mul_q + (66'sd1 <<< 29);
  assign cos_v = neg_q ? -cx_q[32:0] : cx_q[32:0];
  assign sin_v = neg_q ? -cy_q[32:0] : cy_q[32:0];

  // robot position, interval
  logic signed [33:0] sum_x, sum_y;
  logic signed [31:0] sat_x, sat_y;
  logic signed [48:0] dt;
  assign sum_x = 34'(camx_q) + 34'(lever_q) - 34'(dc_q);
  assign sum_y = 34'(camy_q) - 34'(ds_q);
  always_comb begin
    if (sum_x > 34'sh07FFFFFFF) sat_x = 32'sh7FFFFFFF;
    else if (sum_x < -34'sh080000000) sat_x = 32'sh80000000;
    else sat_x = sum_x[31:0];
    if (sum_y > 34'sh07FFFFFFF) sat_y = 32'sh7FFFFFFF;
    else if (sum_y < -34'sh080000000) sat_y = 32'sh80000000;
    else sat_y = sum_y[31:0];
  end
  assign dt = $signed({1'b0, stamp_q}) - $signed({1'b0, last_stamp_q});

  // rate channel selection
  logic signed [32:0] diff, diff_abs;
  always_comb begin
    unique case (ch_q)
      2'd0:    diff = dx_q;
      2'd1:    diff = dy_q;
      default: diff = 33'(dh_q);
    endcase
    diff_abs = (diff < 0) ? -diff : diff;
  end

  // divider check and step
  logic [63:0] nsum;
  logic [48:0] r2;
  logic        ge;
  assign nsum = {1'b0, mul_q[62:0]} + 64'(ud_q >> 1);
  assign r2 = {rem_q, nq_q[31]};
  assign ge = r2 >= {1'b0, ud_q};

  // signed, saturated quotient
  logic signed [31:0] rate_v;
  always_comb begin
    if (rneg_q) begin
      if (big_q || nq_q > 32'h80000000) rate_v = 32'sh80000000;
      else rate_v = -$signed(nq_q);
    end else begin
      if (big_q || nq_q > 32'h7FFFFFFF) rate_v = 32'sh7FFFFFFF;
      else rate_v = $signed(nq_q);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tplo_pkg::S_IDLE:  if (pose_acc) state_d = tplo_pkg::S_MULQ;
      tplo_pkg::S_MULQ:  if (cnt_q == 5'(tplo_pkg::QUAT_PRODS)) state_d = tplo_pkg::S_PREP;
      tplo_pkg::S_PREP: begin
        if (gimbal || num == '0) state_d = tplo_pkg::S_RINIT;
        else state_d = tplo_pkg::S_VEC;
      end
      tplo_pkg::S_VEC:   if (cnt_q == 5'(tplo_pkg::CORDIC_STEPS - 1)) state_d = tplo_pkg::S_ROUND;
      tplo_pkg::S_ROUND: state_d = tplo_pkg::S_RINIT;
      tplo_pkg::S_RINIT: state_d = tplo_pkg::S_ROT;
      tplo_pkg::S_ROT:   if (cnt_q == 5'(tplo_pkg::CORDIC_STEPS - 1)) state_d = tplo_pkg::S_LEVER;
      tplo_pkg::S_LEVER: if (cnt_q == 5'd2) state_d = tplo_pkg::S_POS;
      tplo_pkg::S_POS:   state_d = (dt == '0) ? tplo_pkg::S_FIN : tplo_pkg::S_RMUL;
      tplo_pkg::S_RMUL:  state_d = tplo_pkg::S_RCHK;
      tplo_pkg::S_RCHK: begin
        if (nsum[63:32] >= {16'b0, ud_q}) state_d = tplo_pkg::S_REND;
        else state_d = tplo_pkg::S_RDIV;
      end
      tplo_pkg::S_RDIV:  if (cnt_q == 5'(tplo_pkg::DIV_STEPS - 1)) state_d = tplo_pkg::S_REND;
      tplo_pkg::S_REND:  state_d = (ch_q == 2'd2) ? tplo_pkg::S_FIN : tplo_pkg::S_RMUL;
      tplo_pkg::S_FIN:   if (out_free) state_d = tplo_pkg::S_IDLE;
      default:           state_d = tplo_pkg::S_IDLE;
    endcase
  end

  // outputs: handshakes and multiplier operands
  always_comb begin
    pose_i.ready = (state_q == tplo_pkg::S_IDLE);
    cfg_i.ready  = 1'b1;
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      tplo_pkg::S_MULQ: begin
        unique case (cnt_q)
          5'd0: begin mul_a = 33'(qx_q); mul_b = 33'(qz_q); end
          5'd1: begin mul_a = 33'(qw_q); mul_b = 33'(qy_q); end
          5'd2: begin mul_a = 33'(qw_q); mul_b = 33'(qz_q); end
          5'd3: begin mul_a = 33'(qx_q); mul_b = 33'(qy_q); end
          5'd4: begin mul_a = 33'(qy_q); mul_b = 33'(qy_q); end
          5'd5: begin mul_a = 33'(qz_q); mul_b = 33'(qz_q); end
          default: ;
        endcase
      end
      tplo_pkg::S_LEVER: begin
        mul_a = 33'(lever_q);
        mul_b = (cnt_q == 5'd0) ? cos_v : sin_v;
      end
      tplo_pkg::S_RMUL: begin
        mul_a = diff_abs;
        mul_b = tplo_pkg::NS_PER_S;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tplo_pkg::S_IDLE;
      cnt_q        <= '0;
      ch_q         <= '0;
      lever_q      <= tplo_pkg::LEVER_RST;
      last_stamp_q <= '0;
      last_x_q     <= '0;
      last_y_q     <= '0;
      last_hd_q    <= '0;
      ov_q         <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_d != state_q) ? '0 : cnt_q + 5'd1;
      if (cfg_i.valid) lever_q <= cfg_i.lever_arm;
      if (state_q == tplo_pkg::S_POS) ch_q <= '0;
      else if (state_q == tplo_pkg::S_REND) ch_q <= ch_q + 2'd1;
      if (state_q == tplo_pkg::S_FIN && out_free) ov_q <= 1'b1;
      else if (odom_o.ready) ov_q <= 1'b0;
      if (state_q == tplo_pkg::S_FIN && out_free) begin
        last_stamp_q <= stamp_q;
        last_x_q     <= rx_q;
        last_y_q     <= ry_q;
        last_hd_q    <= hd_q;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    unique case (state_q)
      tplo_pkg::S_IDLE: begin
        if (pose_acc) begin
          stamp_q <= pose_i.stamp_ns;
          camx_q  <= pose_i.cam_x;
          camy_q  <= pose_i.cam_y;
          qx_q    <= pose_i.quat_x;
          qy_q    <= pose_i.quat_y;
          qz_q    <= pose_i.quat_z;
          qw_q    <= pose_i.quat_w;
        end
      end
      tplo_pkg::S_MULQ: begin
        if (cnt_q != '0) prod_q[3'(cnt_q - 5'd1)] <= mul_q[31:0];
      end
      tplo_pkg::S_PREP: begin
        // pre-rotate into the right half plane
        cz_q <= '0;
        cx_q <= CW'(den);
        cy_q <= CW'(num);
        if (gimbal) hd_q <= '0;
        else if (num == '0) hd_q <= (den >= 0) ? '0 : tplo_pkg::PI_Q13;
        if (den < 0) begin
          if (num > 0) begin
            cx_q <= CW'(num);
            cy_q <= -CW'(den);
            cz_q <= tplo_pkg::HALF_PI_Q16;
          end else begin
            cx_q <= -CW'(num);
            cy_q <= CW'(den);
            cz_q <= -tplo_pkg::HALF_PI_Q16;
          end
        end
      end
      tplo_pkg::S_VEC, tplo_pkg::S_ROT: begin
        if (!skip) begin
          cx_q <= xn;
          cy_q <= yn;
          cz_q <= zn;
        end
      end
      tplo_pkg::S_ROUND: hd_q <= hd_rnd;
      tplo_pkg::S_RINIT: begin
        cx_q  <= tplo_pkg::CORDIC_K;
        cy_q  <= '0;
        neg_q <= 1'b0;
        cz_q  <= z8;
        if (z8 > tplo_pkg::HALF_PI_Q16) begin
          cz_q  <= z8 - tplo_pkg::PI_Q16;
          neg_q <= 1'b1;
        end else if (z8 < -tplo_pkg::HALF_PI_Q16) begin
          cz_q  <= z8 + tplo_pkg::PI_Q16;
          neg_q <= 1'b1;
        end
      end
      tplo_pkg::S_LEVER: begin
        if (cnt_q == 5'd1) dc_q <= mul_rnd[53:30];
        if (cnt_q == 5'd2) ds_q <= mul_rnd[53:30];
      end
      tplo_pkg::S_POS: begin
        rx_q   <= sat_x;
        ry_q   <= sat_y;
        dx_q   <= 33'(sat_x) - 33'(last_x_q);
        dy_q   <= 33'(sat_y) - 33'(last_y_q);
        dh_q   <= (20'(hd_q) - 20'(last_hd_q)) <<< 3;
        zero_q <= (dt == '0);
        dneg_q <= dt < 0;
        ud_q   <= (dt < 0) ? 48'(-dt) : dt[47:0];
        vx_q   <= '0;
        vy_q   <= '0;
        vt_q   <= '0;
      end
      tplo_pkg::S_RMUL: rneg_q <= (diff < 0) ^ dneg_q;
      tplo_pkg::S_RCHK: begin
        big_q <= nsum[63:32] >= {16'b0, ud_q};
        rem_q <= 48'(nsum[63:32]);
        nq_q  <= nsum[31:0];
      end
      tplo_pkg::S_RDIV: begin
        rem_q <= ge ? 48'(r2 - {1'b0, ud_q}) : r2[47:0];
        nq_q  <= {nq_q[30:0], ge};
      end
      tplo_pkg::S_REND: begin
        unique case (ch_q)
          2'd0:    vx_q <= rate_v;
          2'd1:    vy_q <= rate_v;
          default: vt_q <= rate_v;
        endcase
      end
      tplo_pkg::S_FIN: begin
        if (out_free) begin
          o_rx_q   <= rx_q;
          o_ry_q   <= ry_q;
          o_hd_q   <= hd_q;
          o_vx_q   <= vx_q;
          o_vy_q   <= vy_q;
          o_vt_q   <= vt_q;
          o_zero_q <= zero_q;
        end
      end
      default: ;
    endcase
  end

  assign odom_o.valid         = ov_q;
  assign odom_o.robot_x       = o_rx_q;
  assign odom_o.robot_y       = o_ry_q;
  assign odom_o.heading       = o_hd_q;
  assign odom_o.vel_x         = o_vx_q;
  assign odom_o.vel_y         = o_vy_q;
  assign odom_o.yaw_rate      = o_vt_q;
  assign odom_o.zero_interval = o_zero_q;

  // checks
  a_acc_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pose_acc |=> state_q == tplo_pkg::S_MULQ)
    else $error("accepted pose did not start the sequencer");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tplo_pkg::S_RDIV |-> rem_q < ud_q)
    else $error("divider remainder not below divisor");

  a_hd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (o_hd_q <= tplo_pkg::PI_Q13) && (o_hd_q >= -tplo_pkg::PI_Q13))
    else $error("heading out of range");

  a_zero_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && o_zero_q |-> o_vx_q == '0 && o_vy_q == '0 && o_vt_q == '0)
    else $error("zero interval with nonzero velocity");

endmodule
